### sv/max_pool_2x2_stream_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the 2x2 max pooling stream block
// Concurrent checks that can be compiled out with ASSERT_OFF.
// ---------------------------------------------------------------------------
`ifndef MAX_POOL_2X2_STREAM_TOP_ASSERT_SVH
`define MAX_POOL_2X2_STREAM_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication
`define MP2S_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("max pool check failed");
// Next-cycle implication
`define MP2S_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("max pool check failed");
`else
`define MP2S_ASSERT_SAME(label, clk, rst, ante, cons)
`define MP2S_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### sv/mp2s_pkg.sv
// ---------------------------------------------------------------------------
// mp2s_pkg
// Shared widths and register indexes of the 2x2 max pooling stream block.
// ---------------------------------------------------------------------------
package mp2s_pkg;

   localparam int FIELD_W   = 32;   // pixel and pooled value fields
   localparam int CSR_DATA_W = 11;  // widest configuration register
   localparam int CSR_IDX_W  = 1;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   localparam csr_idx_type CSR_IMAGE_ROWS = 1'b0;
   localparam csr_idx_type CSR_IMAGE_COLS = 1'b1;

   typedef logic signed [FIELD_W-1:0] field_type;

endpackage

### sv/mp2s_stream_if.sv
// ---------------------------------------------------------------------------
// mp2s_req_if / mp2s_rsp_if
// Valid/ready channels for pixel input and pooled result output.
// ---------------------------------------------------------------------------
interface mp2s_req_if;
   import mp2s_pkg::*;

   logic      valid;
   logic      ready;
   field_type pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

interface mp2s_rsp_if;
   import mp2s_pkg::*;

   logic      valid;
   logic      ready;
   field_type pooled_value;
   logic      last_of_image;

   modport source (output valid, output pooled_value, output last_of_image, input ready);
   modport sink   (input valid, input pooled_value, input last_of_image, output ready);
endinterface

### sv/max_pool_2x2_stream_top.sv
// ---------------------------------------------------------------------------
// max_pool_2x2_stream_top
// Streaming 2x2 max pooling, stride 2, zero padding at odd edges.
// ---------------------------------------------------------------------------
// Usage:
//   req_chan carries one pixel per transfer in raster order; rsp_chan
//   carries one pooled value per completed 2x2 window, raster order of the
//   pooled image, with last_of_image set on the final value of an image.
//   csr_wr_en/csr_index/csr_data write image_rows (index 0) and image_cols
//   (index 1); any write restarts the image. Write only while idle.
// Throughput: one pixel per cycle while rsp_chan does not stall. A pixel
//   costs at most one access to the line store (a write when it closes a
//   pair on an upper row, a read when it closes a pair on a lower row), so
//   the single memory port never limits the rate.
// Path: a window's result passes the read stage (line store read) and
//   then the output register before it is presented on rsp_chan.
// Reset: synchronous; positions clear to the start of an image and the
//   dimensions return to 1 x 1. The line store is not cleared: every entry
//   is written by an upper row before its lower row reads it.
// Stall: a held result waits in the output register while one more result
//   sits in the read stage; req_chan.ready drops only when both are full.
// ---------------------------------------------------------------------------
`include "max_pool_2x2_stream_top_assert.svh"

module max_pool_2x2_stream_top #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int PIXEL_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   mp2s_req_if.sink               req_chan,
   mp2s_rsp_if.source             rsp_chan,
   input  logic                   csr_wr_en,
   input  mp2s_pkg::csr_idx_type  csr_index,
   input  mp2s_pkg::csr_data_type csr_data
);
   import mp2s_pkg::*;

   localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
   localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int COLD_W     = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int ROWD_W     = $clog2(MAX_HEIGHT + 1);

   typedef logic signed [PIXEL_BITS-1:0] pix_type;

   // effective image size
   logic [ROWD_W-1:0] rows_eff_ff, rows_eff_in;
   logic [COLD_W-1:0] cols_eff_ff, cols_eff_in;

   // scan position and running maximum of the current pixel pair
   logic [ROW_W-1:0]  row_pos_ff, row_pos_in;
   logic [COL_W-1:0]  col_pos_ff, col_pos_in;
   pix_type           pair_max_ff, pair_max_in;

   // read stage (waits for the line store)
   logic    s1_valid_ff, s1_valid_in;
   pix_type s1_part_ff;
   logic    s1_use_mem_ff;
   logic    s1_last_ff;

   // output register
   logic    rsp_valid_ff, rsp_valid_in;
   pix_type rsp_value_ff;
   logic    rsp_last_ff;

   logic    req_accept;
   logic    s1_advance;
   logic    last_col, last_row, odd_col, odd_row, row_done;
   pix_type px, part, part_out, mem_rd_data, merged;
   logic    mem_wr_en, mem_rd_en, emit;
   logic [ADDR_W-1:0] mem_addr;

   // --- handshake -----------------------------------------------------------
   // The read stage moves on when the output register is empty or drains.
   assign s1_advance     = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || s1_advance;
   assign req_accept     = req_chan.valid && req_chan.ready;

   // --- configuration -------------------------------------------------------
   // Clamp the dimensions once at the write: zero acts as one, oversize as max.
   always_comb begin
      rows_eff_in = rows_eff_ff;
      cols_eff_in = cols_eff_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_IMAGE_ROWS: begin
               if (csr_data == '0) begin
                  rows_eff_in = ROWD_W'(1);
               end else if (32'(csr_data) > MAX_HEIGHT) begin
                  rows_eff_in = ROWD_W'(MAX_HEIGHT);
               end else begin
                  rows_eff_in = ROWD_W'(csr_data);
               end
            end
            CSR_IMAGE_COLS: begin
               if (csr_data == '0) begin
                  cols_eff_in = COLD_W'(1);
               end else if (32'(csr_data) > MAX_WIDTH) begin
                  cols_eff_in = COLD_W'(MAX_WIDTH);
               end else begin
                  cols_eff_in = COLD_W'(csr_data);
               end
            end
            default: begin
            end
         endcase
      end
   end

   // --- window front end ----------------------------------------------------
   assign px       = pix_type'(req_chan.pixel[PIXEL_BITS-1:0]);
   assign odd_col  = col_pos_ff[0];
   assign odd_row  = row_pos_ff[0];
   assign last_col = (COLD_W'(col_pos_ff) + COLD_W'(1)) >= cols_eff_ff;
   assign last_row = (ROWD_W'(row_pos_ff) + ROWD_W'(1)) >= rows_eff_ff;
   assign row_done = odd_col || last_col;

   // Row half of the window: pair maximum, or pixel against a zero neighbour.
   always_comb begin
      if (odd_col) begin
         part = (px > pair_max_ff) ? px : pair_max_ff;
      end else begin
         part = (px > pix_type'(0)) ? px : pix_type'(0);
      end
   end

   // A bottom-edge window on an even row has a zero lower row.
   assign part_out  = (!odd_row && part < pix_type'(0)) ? pix_type'(0) : part;

   assign mem_addr  = ADDR_W'(col_pos_ff >> 1);
   assign mem_wr_en = req_accept && row_done && !odd_row && !last_row;
   assign mem_rd_en = req_accept && row_done && odd_row;
   assign emit      = req_accept && row_done && (odd_row || last_row);

   always_comb begin
      row_pos_in  = row_pos_ff;
      col_pos_in  = col_pos_ff;
      pair_max_in = pair_max_ff;
      if (csr_wr_en) begin
         // restart the image on any register write
         row_pos_in  = '0;
         col_pos_in  = '0;
         pair_max_in = '0;
      end else if (req_accept) begin
         if (last_col) begin
            col_pos_in  = '0;
            row_pos_in  = last_row ? '0 : row_pos_ff + ROW_W'(1);
            pair_max_in = '0;
         end else begin
            col_pos_in  = col_pos_ff + COL_W'(1);
            pair_max_in = odd_col ? part : px;
         end
      end
   end

   // --- line store of upper-row maxima ---------------------------------------
   mp2s_line_mem #(
      .DEPTH  (LINE_DEPTH),
      .ADDR_W (ADDR_W),
      .DATA_W (PIXEL_BITS)
   ) u_line_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .rd_en   (mem_rd_en),
      .addr    (mem_addr),
      .wr_data (part),
      .rd_data (mem_rd_data)
   );

   // --- read stage and output register --------------------------------------
   assign merged = (s1_use_mem_ff && mem_rd_data > s1_part_ff) ? mem_rd_data : s1_part_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_chan.ready) begin
         s1_valid_in = emit;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_eff_ff  <= ROWD_W'(1);
         cols_eff_ff  <= COLD_W'(1);
         row_pos_ff   <= '0;
         col_pos_ff   <= '0;
         pair_max_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rows_eff_ff  <= rows_eff_in;
         cols_eff_ff  <= cols_eff_in;
         row_pos_ff   <= row_pos_in;
         col_pos_ff   <= col_pos_in;
         pair_max_ff  <= pair_max_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: hold while stalled
   always_ff @(posedge clock) begin
      if (emit) begin
         s1_part_ff    <= part_out;
         s1_use_mem_ff <= odd_row;
         s1_last_ff    <= last_col && last_row;
      end
      if (s1_advance && s1_valid_ff) begin
         rsp_value_ff <= merged;
         rsp_last_ff  <= s1_last_ff;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.pooled_value  = field_type'(32'($unsigned(rsp_value_ff)));
   assign rsp_chan.last_of_image = rsp_last_ff;

   // --- assertions -----------------------------------------------------------
   `MP2S_ASSERT_SAME(a_stall_blocks_input, clock, reset,
      s1_valid_ff && rsp_valid_ff && !rsp_chan.ready, !req_chan.ready)
   `MP2S_ASSERT_NEXT(a_read_fills_stage, clock, reset,
      mem_rd_en, s1_valid_ff && s1_use_mem_ff)
   `MP2S_ASSERT_SAME(a_col_in_range, clock, reset,
      1'b1, COLD_W'(col_pos_ff) < cols_eff_ff)

endmodule

### sv/mp2s_line_mem.sv
// ---------------------------------------------------------------------------
// mp2s_line_mem
// Single-port line store with registered read.
// ---------------------------------------------------------------------------
module mp2s_line_mem #(
   parameter int DEPTH  = 512,
   parameter int ADDR_W = 9,
   parameter int DATA_W = 32
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] addr,
   input  logic [DATA_W-1:0] wr_data,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
